// ===== rtl/core/sla_pkg.sv =====
// Shared types and constants of the serial line assembler.
`default_nettype none

package sla_pkg;

  // Default sizes
  localparam int unsigned RingLinesDef  = 64;
  localparam int unsigned MaxColumnsDef = 64;

  // Register reset values
  localparam logic [6:0] WrapReset = 7'd40;
  localparam logic [6:0] RowsReset = 7'd33;

  // Register index, taken from paddr[2]
  localparam logic RegWrap = 1'b0;
  localparam logic RegRows = 1'b1;

  // Character codes
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] PrintLow  = 8'h20;
  localparam logic [7:0] PrintHigh = 8'h7E;

  // Operation carried by an input word
  typedef enum logic [1:0] {
    ModeByte  = 2'd0,
    ModeFlush = 2'd1,
    ModeClear = 2'd2,
    ModeRead  = 2'd3
  } mode_e;

  // Raw configuration register contents
  typedef struct packed {
    logic [6:0] wrap_columns;
    logic [6:0] visible_rows;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_line_assembler_scrollback.sv =====
// Byte, flush and clear words: status word registered once the output slot is free.
// Row read: length lookup, then one character word per cycle while the sink is ready;
// the character memory port sets that pace.
// A new word is accepted only once the previous one has handed all its results over.
// Reset clears counters, ring pointers and handshake state at once; the character and
// length memories are not cleared, as only entries written since the last clear are read.
`default_nettype none

module serial_line_assembler_scrollback #(
  parameter int unsigned RingLines  = sla_pkg::RingLinesDef,
  parameter int unsigned MaxColumns = sla_pkg::MaxColumnsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [5:0]  row_index_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       text_char_o,
  output logic             is_last_o,
  output logic             line_empty_o,
  output logic [6:0]       lines_held_o,
  output logic [6:0]       pending_chars_o,
  output logic [31:0]      bytes_received_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import sla_pkg::*;

  localparam int unsigned RowW = $clog2(RingLines + 1);
  localparam int unsigned ColW = $clog2(MaxColumns);
  localparam int unsigned LenW = $clog2(MaxColumns + 1);

  cfg_t                  cfg;
  logic                  st_we;
  logic [RowW+ColW-1:0]  st_waddr;
  logic [7:0]            st_wdata;
  logic                  st_re;
  logic [RowW+ColW-1:0]  st_raddr;
  logic [7:0]            st_rdata;
  logic                  ln_we;
  logic [RowW-1:0]       ln_waddr;
  logic [LenW-1:0]       ln_wdata;
  logic                  ln_re;
  logic [RowW-1:0]       ln_raddr;
  logic [LenW-1:0]       ln_rdata;

  sla_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // One spare row holds the line being assembled
  sla_ram #(
    .Width (8),
    .Depth ((RingLines + 1) * (2 ** ColW))
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  sla_ram #(
    .Width (LenW),
    .Depth (RingLines + 1)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .re_i    (ln_re),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  sla_engine #(
    .RingLines  (RingLines),
    .MaxColumns (MaxColumns)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .rx_byte_i        (rx_byte_i),
    .row_index_i      (row_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .text_char_o      (text_char_o),
    .is_last_o        (is_last_o),
    .line_empty_o     (line_empty_o),
    .lines_held_o     (lines_held_o),
    .pending_chars_o  (pending_chars_o),
    .bytes_received_o (bytes_received_o),
    .st_we_o          (st_we),
    .st_waddr_o       (st_waddr),
    .st_wdata_o       (st_wdata),
    .st_re_o          (st_re),
    .st_raddr_o       (st_raddr),
    .st_rdata_i       (st_rdata),
    .ln_we_o          (ln_we),
    .ln_waddr_o       (ln_waddr),
    .ln_wdata_o       (ln_wdata),
    .ln_re_o          (ln_re),
    .ln_raddr_o       (ln_raddr),
    .ln_rdata_i       (ln_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sla_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: hold the last data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/sla_cfg.sv =====
// APB-style configuration registers: wrap width and visible window rows.
`default_nettype none

module sla_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output sla_pkg::cfg_t      cfg_o
);

  import sla_pkg::*;

  logic [6:0] wrap_q, wrap_d;
  logic [6:0] rows_q, rows_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode the write
  always_comb begin
    wrap_d = wrap_q;
    rows_d = rows_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegWrap: wrap_d = pwdata[6:0];
        RegRows: rows_d = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= WrapReset;
      rows_q <= RowsReset;
    end else begin
      wrap_q <= wrap_d;
      rows_q <= rows_d;
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      RegWrap: prdata = {25'd0, wrap_q};
      RegRows: prdata = {25'd0, rows_q};
      default: prdata = 32'd0;
    endcase
  end

  // Pack the registers in field order: wrap width, then window rows
  assign cfg_o = {wrap_q, rows_q};

endmodule

`default_nettype wire

// ===== rtl/core/sla_engine.sv =====
// Line assembly, ring bookkeeping and row read sequencer around the two memories.
`default_nettype none

module sla_engine #(
  parameter int unsigned RingLines  = sla_pkg::RingLinesDef,
  parameter int unsigned MaxColumns = sla_pkg::MaxColumnsDef,
  localparam int unsigned RowW = $clog2(RingLines + 1),
  localparam int unsigned ColW = $clog2(MaxColumns),
  localparam int unsigned LenW = $clog2(MaxColumns + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sla_pkg::cfg_t          cfg_i,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic [7:0]             rx_byte_i,
  input  wire logic [5:0]             row_index_i,
  // output channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        kind_o,
  output logic [7:0]                  text_char_o,
  output logic                        is_last_o,
  output logic                        line_empty_o,
  output logic [6:0]                  lines_held_o,
  output logic [6:0]                  pending_chars_o,
  output logic [31:0]                 bytes_received_o,
  // character store
  output logic                        st_we_o,
  output logic [RowW+ColW-1:0]        st_waddr_o,
  output logic [7:0]                  st_wdata_o,
  output logic                        st_re_o,
  output logic [RowW+ColW-1:0]        st_raddr_o,
  input  wire logic [7:0]             st_rdata_i,
  // line length store
  output logic                        ln_we_o,
  output logic [RowW-1:0]             ln_waddr_o,
  output logic [LenW-1:0]             ln_wdata_o,
  output logic                        ln_re_o,
  output logic [RowW-1:0]             ln_raddr_o,
  input  wire logic [LenW-1:0]        ln_rdata_i
);

  import sla_pkg::*;

  localparam int unsigned SumW  = $clog2(2 * RingLines + 2);
  localparam int unsigned PhysN = RingLines + 1;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StLen  = 4'b0010,
    StChr  = 4'b0100,
    StStat = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [RowW-1:0] head_q, head_d;
  logic [RowW-1:0] fill_q, fill_d;
  logic [LenW-1:0] pend_q, pend_d;
  logic [31:0]     total_q, total_d;
  logic [RowW-1:0] phys_q, phys_d;
  logic            hit_q, hit_d;
  logic            empty_q, empty_d;
  logic [ColW-1:0] col_q, col_d;
  logic [LenW-1:0] len_q, len_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, kind_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;
  logic            oempty_q, oempty_d;
  logic [6:0]      held_q, held_d;
  logic [6:0]      opend_q, opend_d;
  logic [31:0]     obytes_q, obytes_d;

  mode_e           mode;
  logic            accept;
  logic            out_free;
  logic [LenW-1:0] eff_width;
  logic [RowW-1:0] eff_rows;
  logic [RowW-1:0] vis;
  logic            in_win;
  logic [SumW-1:0] sum;
  logic [RowW-1:0] head_next;
  logic [RowW-1:0] fill_next;
  logic [LenW-1:0] pend_inc;
  logic [7:0]      kept;
  logic            is_lf;
  logic            is_cr;
  logic            commit;
  logic            chr_last;

  assign mode     = mode_e'(mode_i);
  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || out_ready_i;

  // Clamp the configured width and window
  always_comb begin
    if (cfg_i.wrap_columns == 7'd0) begin
      eff_width = LenW'(1);
    end else if (32'(cfg_i.wrap_columns) > 32'(MaxColumns)) begin
      eff_width = LenW'(MaxColumns);
    end else begin
      eff_width = LenW'(cfg_i.wrap_columns);
    end
    if (cfg_i.visible_rows == 7'd0) begin
      eff_rows = RowW'(1);
    end else if (32'(cfg_i.visible_rows) > 32'(RingLines)) begin
      eff_rows = RowW'(RingLines);
    end else begin
      eff_rows = RowW'(cfg_i.visible_rows);
    end
  end

  // Map a visible row onto a physical row; the pending line owns row head_q
  assign vis    = (fill_q < eff_rows) ? fill_q : eff_rows;
  assign in_win = 32'(row_index_i) < 32'(vis);
  assign sum    = SumW'(head_q) + SumW'(PhysN) - SumW'(vis) + SumW'(row_index_i);
  assign phys_d = (sum >= SumW'(PhysN)) ? RowW'(sum - SumW'(PhysN)) : RowW'(sum);

  assign head_next = (head_q == RowW'(RingLines)) ? '0 : head_q + 1'b1;
  assign fill_next = (fill_q == RowW'(RingLines)) ? fill_q : fill_q + 1'b1;
  assign pend_inc  = pend_q + 1'b1;

  // Replace unprintable bytes
  assign is_lf = (rx_byte_i == CharLf);
  assign is_cr = (rx_byte_i == CharCr);
  assign kept  = (rx_byte_i >= PrintLow && rx_byte_i <= PrintHigh) ? rx_byte_i : CharDot;

  // Decide whether this word closes the pending line
  always_comb begin
    commit     = 1'b0;
    ln_wdata_o = pend_q;
    case (mode)
      ModeByte: begin
        if (is_lf) begin
          commit = (pend_q != '0);
        end else if (!is_cr) begin
          commit     = (pend_inc >= eff_width);
          ln_wdata_o = pend_inc;
        end
      end
      ModeFlush: commit = (pend_q != '0);
      default:   commit = 1'b0;
    endcase
    commit = commit && accept;
  end

  // Append the character straight into the pending row of the store
  assign st_we_o    = accept && (mode == ModeByte) && !is_lf && !is_cr;
  assign st_waddr_o = {head_q, pend_q[ColW-1:0]};
  assign st_wdata_o = kept;
  assign ln_we_o    = commit;
  assign ln_waddr_o = head_q;
  assign ln_re_o    = accept && (mode == ModeRead);
  assign ln_raddr_o = phys_d;

  assign chr_last = ((LenW'(col_q) + 1'b1) == len_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    total_d     = total_q;
    hit_d       = hit_q;
    empty_d     = empty_q;
    col_d       = col_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    char_d      = char_q;
    last_d      = last_q;
    oempty_d    = oempty_q;
    held_d      = held_q;
    opend_d     = opend_q;
    obytes_d    = obytes_q;
    st_re_o     = 1'b0;
    st_raddr_o  = {phys_q, ColW'(0)};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          hit_d   = in_win;
          empty_d = 1'b0;
          case (mode)
            ModeByte: begin
              total_d = total_q + 32'd1;
              if (!is_lf && !is_cr) begin
                pend_d = pend_inc;
              end
              state_d = StStat;
            end
            ModeClear: begin
              head_d  = '0;
              fill_d  = '0;
              pend_d  = '0;
              total_d = 32'd0;
              state_d = StStat;
            end
            ModeRead: state_d = StLen;
            default:  state_d = StStat;
          endcase
          if (commit) begin
            head_d = head_next;
            fill_d = fill_next;
            pend_d = '0;
          end
        end
      end

      StLen: begin
        if (hit_q && ln_rdata_i != '0) begin
          len_d   = ln_rdata_i;
          col_d   = '0;
          st_re_o = 1'b1;
          state_d = StChr;
        end else begin
          empty_d = 1'b1;
          state_d = StStat;
        end
      end

      StChr: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b1;
          char_d      = st_rdata_i;
          last_d      = chr_last;
          oempty_d    = 1'b0;
          held_d      = 7'(fill_q);
          opend_d     = 7'(pend_q);
          obytes_d    = total_q;
          if (chr_last) begin
            state_d = StIdle;
          end else begin
            col_d      = col_q + 1'b1;
            st_re_o    = 1'b1;
            st_raddr_o = {phys_q, col_q + 1'b1};
          end
        end
      end

      StStat: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          char_d      = 8'd0;
          last_d      = 1'b1;
          oempty_d    = empty_q;
          held_d      = 7'(fill_q);
          opend_d     = 7'(pend_q);
          obytes_d    = total_q;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      fill_q      <= '0;
      pend_q      <= '0;
      total_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and per-read registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      phys_q <= phys_d;
    end
    hit_q    <= hit_d;
    empty_q  <= empty_d;
    col_q    <= col_d;
    len_q    <= len_d;
    kind_q   <= kind_d;
    char_q   <= char_d;
    last_q   <= last_d;
    oempty_q <= oempty_d;
    held_q   <= held_d;
    opend_q  <= opend_d;
    obytes_q <= obytes_d;
  end

  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign text_char_o      = char_q;
  assign is_last_o        = last_q;
  assign line_empty_o     = oempty_q;
  assign lines_held_o     = held_q;
  assign pending_chars_o  = opend_q;
  assign bytes_received_o = obytes_q;

endmodule

`default_nettype wire
